@@ src/jsv_pkg.sv @@
package jsv_pkg;

    localparam int DEF_MAX_DEPTH = 64;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [3:0] {
        M_VALUE      = 4'd0,
        M_OPEN_ARR   = 4'd1,
        M_OPEN_OBJ   = 4'd2,
        M_KEY        = 4'd3,
        M_STRING     = 4'd4,
        M_ESCAPE     = 4'd5,
        M_HEX        = 4'd6,
        M_COLON      = 4'd7,
        M_SCALAR     = 4'd8,
        M_AFTER_ELEM = 4'd9,
        M_AFTER_TOP  = 4'd10,
        M_FAIL       = 4'd11
    } t_mode;

    // Kind bit of a nesting level: 1 = object, 0 = array.
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        logic kind;
    } t_stack_op;

    typedef struct packed {
        logic empty;
        logic one;
        logic full;
        logic top_kind;
    } t_stack_stat;

endpackage

@@ src/jsv_ram.sv @@
module jsv_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/jsv_stack.sv @@
module jsv_stack #(
    parameter int MAX_DEPTH = jsv_pkg::DEF_MAX_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jsv_pkg::t_stack_op  i_op,
    output jsv_pkg::t_stack_stat o_stat
);

    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // The top kind lives in a flop; the levels below it live in the RAM,
    // whose read port always prefetches the entry just under the top.
    logic [LW-1:0] r_level;
    logic [LW-1:0] n_level;
    logic          r_top;
    logic          n_top;
    logic          r_byp;
    logic          r_byp_kind;
    logic          below_kind;
    logic          ram_q;
    logic          ram_we;
    logic [LW-1:0] waddr_full;
    logic [LW-1:0] raddr_full;
    logic          do_push;
    logic          do_pop;

    assign do_push = i_op.push && !i_op.clear;
    assign do_pop  = i_op.pop && !i_op.clear;

    // A push writes the same address that the prefetch reads, so the value
    // written to the RAM is forwarded from a register.
    assign below_kind = r_byp ? r_byp_kind : ram_q;

    always_comb begin
        n_level = r_level;
        n_top   = r_top;
        if (i_op.clear) begin
            n_level = '0;
        end else if (do_push) begin
            n_level = r_level + LW'(1);
            n_top   = i_op.kind;
        end else if (do_pop) begin
            n_level = r_level - LW'(1);
            n_top   = below_kind;
        end
    end

    assign ram_we     = do_push && (r_level != '0);
    assign waddr_full = r_level - LW'(1);
    assign raddr_full = n_level - LW'(2);

    jsv_ram #(
        .WIDTH (1),
        .DEPTH (MAX_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr_full[AW-1:0]),
        .i_wdata (r_top),
        .i_raddr (raddr_full[AW-1:0]),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_byp   <= 1'b0;
        end else begin
            r_level <= n_level;
            r_byp   <= do_push;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_byp_kind <= r_top;
    end

    assign o_stat.empty    = (r_level == '0);
    assign o_stat.one      = (r_level == LW'(1));
    assign o_stat.full     = (r_level == LW'(MAX_DEPTH));
    assign o_stat.top_kind = r_top;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push |-> (r_level != LW'(MAX_DEPTH)))
        else $error("push while the nesting stack is full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop |-> (r_level != '0))
        else $error("pop while the nesting stack is empty");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(MAX_DEPTH))
        else $error("nesting level beyond its limit");

    a_push_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push |=> (r_level == $past(r_level) + LW'(1)) && r_byp)
        else $error("push did not advance the level");

endmodule

@@ src/jsv_parse.sv @@
module jsv_parse (
    input  logic                 [7:0] i_byte,
    input  jsv_pkg::t_mode             i_mode,
    input  logic                       i_in_key,
    input  logic                 [1:0] i_hex,
    input  jsv_pkg::t_stack_stat       i_stat,
    output jsv_pkg::t_mode             o_mode,
    output logic                       o_in_key,
    output logic                 [1:0] o_hex,
    output logic                       o_ovf_set,
    output jsv_pkg::t_stack_op         o_op
);

    logic           is_ws;
    logic           is_delim;
    // Start of a value.
    jsv_pkg::t_mode sv_mode;
    logic           sv_key_clr;
    logic           sv_push;
    logic           sv_ovf;
    // Close of a container.
    jsv_pkg::t_mode cl_mode;
    logic           cl_pop;
    // Byte after a complete element inside a container.
    jsv_pkg::t_mode ae_mode;
    logic           ae_pop;
    jsv_pkg::t_mode done_mode;
    logic           is_open;

    assign is_ws = (i_byte == jsv_pkg::CH_SPACE) ||
                   ((i_byte >= jsv_pkg::CH_TAB) && (i_byte <= jsv_pkg::CH_CR));
    assign is_delim = (i_byte == jsv_pkg::CH_COMMA) || (i_byte == jsv_pkg::CH_RBRACE) ||
                      (i_byte == jsv_pkg::CH_RBRACK);
    assign is_open = (i_byte == jsv_pkg::CH_LBRACE) || (i_byte == jsv_pkg::CH_LBRACK);
    assign done_mode = i_stat.empty ? jsv_pkg::M_AFTER_TOP : jsv_pkg::M_AFTER_ELEM;

    always_comb begin
        sv_key_clr = 1'b0;
        sv_push    = 1'b0;
        sv_ovf     = 1'b0;
        if (i_byte == jsv_pkg::CH_QUOTE) begin
            sv_mode    = jsv_pkg::M_STRING;
            sv_key_clr = 1'b1;
        end else if (is_open) begin
            if (i_stat.full) begin
                sv_mode = jsv_pkg::M_FAIL;
                sv_ovf  = 1'b1;
            end else begin
                sv_push = 1'b1;
                sv_mode = (i_byte == jsv_pkg::CH_LBRACE) ? jsv_pkg::M_OPEN_OBJ
                                                         : jsv_pkg::M_OPEN_ARR;
            end
        end else if (is_delim) begin
            sv_mode = jsv_pkg::M_FAIL;
        end else begin
            sv_mode = jsv_pkg::M_SCALAR;
        end
    end

    always_comb begin
        cl_pop = 1'b0;
        if (i_stat.empty) begin
            cl_mode = jsv_pkg::M_FAIL;
        end else begin
            cl_pop  = 1'b1;
            cl_mode = i_stat.one ? jsv_pkg::M_AFTER_TOP : jsv_pkg::M_AFTER_ELEM;
        end
    end

    always_comb begin
        ae_pop = 1'b0;
        if (i_stat.empty) begin
            ae_mode = jsv_pkg::M_FAIL;
        end else if (i_byte == jsv_pkg::CH_COMMA) begin
            ae_mode = i_stat.top_kind ? jsv_pkg::M_KEY : jsv_pkg::M_VALUE;
        end else if ((i_byte == jsv_pkg::CH_RBRACE && i_stat.top_kind) ||
                     (i_byte == jsv_pkg::CH_RBRACK && !i_stat.top_kind)) begin
            ae_mode = cl_mode;
            ae_pop  = cl_pop;
        end else begin
            ae_mode = jsv_pkg::M_FAIL;
        end
    end

    always_comb begin
        o_mode    = i_mode;
        o_in_key  = i_in_key;
        o_hex     = i_hex;
        o_ovf_set = 1'b0;
        o_op      = '0;
        o_op.kind = (i_byte == jsv_pkg::CH_LBRACE);
        unique case (i_mode)
            jsv_pkg::M_VALUE: begin
                if (!is_ws) begin
                    o_mode    = sv_mode;
                    o_in_key  = i_in_key && !sv_key_clr;
                    o_op.push = sv_push;
                    o_ovf_set = sv_ovf;
                end
            end
            jsv_pkg::M_OPEN_ARR: begin
                if (!is_ws) begin
                    if (i_byte == jsv_pkg::CH_RBRACK) begin
                        o_mode   = cl_mode;
                        o_op.pop = cl_pop;
                    end else begin
                        o_mode    = sv_mode;
                        o_in_key  = i_in_key && !sv_key_clr;
                        o_op.push = sv_push;
                        o_ovf_set = sv_ovf;
                    end
                end
            end
            jsv_pkg::M_OPEN_OBJ, jsv_pkg::M_KEY: begin
                if (!is_ws) begin
                    if (i_byte == jsv_pkg::CH_RBRACE && i_mode == jsv_pkg::M_OPEN_OBJ) begin
                        o_mode   = cl_mode;
                        o_op.pop = cl_pop;
                    end else if (i_byte == jsv_pkg::CH_QUOTE) begin
                        o_in_key = 1'b1;
                        o_mode   = jsv_pkg::M_STRING;
                    end else begin
                        o_mode = jsv_pkg::M_FAIL;
                    end
                end
            end
            jsv_pkg::M_STRING: begin
                if (i_byte == jsv_pkg::CH_QUOTE) begin
                    if (i_in_key) begin
                        o_in_key = 1'b0;
                        o_mode   = jsv_pkg::M_COLON;
                    end else begin
                        o_mode = done_mode;
                    end
                end else if (i_byte == jsv_pkg::CH_BSLASH) begin
                    o_mode = jsv_pkg::M_ESCAPE;
                end
            end
            jsv_pkg::M_ESCAPE: begin
                if (i_byte == jsv_pkg::CH_LOW_U) begin
                    o_hex  = 2'd3;
                    o_mode = jsv_pkg::M_HEX;
                end else begin
                    o_mode = jsv_pkg::M_STRING;
                end
            end
            jsv_pkg::M_HEX: begin
                if (i_hex == 2'd0) begin
                    o_mode = jsv_pkg::M_STRING;
                end else begin
                    o_hex = i_hex - 2'd1;
                end
            end
            jsv_pkg::M_COLON: begin
                if (!is_ws) begin
                    o_mode = (i_byte == jsv_pkg::CH_COLON) ? jsv_pkg::M_VALUE
                                                           : jsv_pkg::M_FAIL;
                end
            end
            jsv_pkg::M_SCALAR: begin
                // A delimiter ends the scalar and is then taken as the byte
                // after a complete element.
                if (is_ws) begin
                    o_mode = done_mode;
                end else if (is_delim) begin
                    if (i_stat.empty) begin
                        o_mode = jsv_pkg::M_FAIL;
                    end else begin
                        o_mode   = ae_mode;
                        o_op.pop = ae_pop;
                    end
                end
            end
            jsv_pkg::M_AFTER_ELEM: begin
                if (!is_ws) begin
                    o_mode   = ae_mode;
                    o_op.pop = ae_pop;
                end
            end
            jsv_pkg::M_AFTER_TOP: begin
                if (!is_ws) begin
                    o_mode = jsv_pkg::M_FAIL;
                end
            end
            default: begin
                o_mode = jsv_pkg::M_FAIL;
            end
        endcase
    end

endmodule

@@ src/json_syntax_validator.sv @@
// JSON syntax checker for a byte stream.
// Input channel (i_s_*): one document byte per transfer, i_s_tlast set on the
// final byte of a document. Output channel (o_m_*): one verdict transfer per
// document, issued for the last byte only; nothing comes out for other bytes.
// The verdict carries valid_res (document well formed) and too_deep (nesting
// went past MAX_DEPTH levels; the document then also reads as invalid).
// Throughput is one byte per clock. A byte is captured in the input register
// and processed from there; when a last byte is processed, its verdict is
// loaded into the output register, which drives o_m_tvalid. The nesting
// stack keeps its top entry in a flop and the rest in a RAM whose registered
// read always prefetches the entry below the top, so a close can follow a
// close in consecutive cycles.
// When a verdict waits on a stalled receiver, bytes of the next document keep
// flowing; only a further last byte holds in the input register, and then
// o_s_tready drops until the pending verdict is taken.
// Reset clears all control state; the stack RAM needs no clearing, since a
// level is read only after it was pushed. After each last byte the parser
// returns to its reset state for the next document.
module json_syntax_validator #(
    parameter int MAX_DEPTH = jsv_pkg::DEF_MAX_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // last_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] valid_res, [1] too_deep, [7:2] zero
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;
    jsv_pkg::t_mode       r_mode;
    jsv_pkg::t_mode       n_mode;
    logic                 r_in_key;
    logic                 n_in_key;
    logic [1:0]           r_hex;
    logic [1:0]           n_hex;
    logic                 r_ovf;
    logic                 ovf_set;
    logic                 r_out_valid;
    logic                 r_out_ok;
    logic                 r_out_deep;
    logic                 proc;
    logic                 s_accept;
    logic                 verdict_ok;
    logic                 verdict_deep;
    jsv_pkg::t_stack_op   parse_op;
    jsv_pkg::t_stack_op   stack_op;
    jsv_pkg::t_stack_stat stat;

    // A non-final byte never waits on the output side.
    assign proc       = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || proc;
    assign s_accept   = i_s_tvalid && o_s_tready;

    jsv_parse u_parse (
        .i_byte    (r_in_byte),
        .i_mode    (r_mode),
        .i_in_key  (r_in_key),
        .i_hex     (r_hex),
        .i_stat    (stat),
        .o_mode    (n_mode),
        .o_in_key  (n_in_key),
        .o_hex     (n_hex),
        .o_ovf_set (ovf_set),
        .o_op      (parse_op)
    );

    always_comb begin
        stack_op = '0;
        if (proc) begin
            if (r_in_last) begin
                stack_op.clear = 1'b1;
            end else begin
                stack_op = parse_op;
            end
        end
    end

    jsv_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (stack_op),
        .o_stat  (stat)
    );

    // A scalar can only be in progress at the level it started on, so the
    // current level decides whether it completes the document.
    assign verdict_deep = r_ovf || ovf_set;
    assign verdict_ok   = !verdict_deep &&
                          ((n_mode == jsv_pkg::M_AFTER_TOP) ||
                           (n_mode == jsv_pkg::M_SCALAR && stat.empty));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mode      <= jsv_pkg::M_VALUE;
            r_in_key    <= 1'b0;
            r_hex       <= 2'd0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                if (r_in_last) begin
                    r_mode   <= jsv_pkg::M_VALUE;
                    r_in_key <= 1'b0;
                    r_hex    <= 2'd0;
                    r_ovf    <= 1'b0;
                end else begin
                    r_mode   <= n_mode;
                    r_in_key <= n_in_key;
                    r_hex    <= n_hex;
                    r_ovf    <= verdict_deep;
                end
            end
            if (proc && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (proc && r_in_last) begin
            r_out_ok   <= verdict_ok;
            r_out_deep <= verdict_deep;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_deep, r_out_ok};

    a_verdict_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("pending verdict changed before its transfer");

    a_deep_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1]) |-> !o_m_tdata[0])
        else $error("too-deep document reported as valid");

    a_fresh_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_last) |=> (r_mode == jsv_pkg::M_VALUE) && !r_ovf && stat.empty)
        else $error("parser not returned to its start state after a document");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf && !(proc && r_in_last)) |=> r_ovf && (r_mode == jsv_pkg::M_FAIL))
        else $error("overflow mark lost within a document");

endmodule

@@ test/json_syntax_validator_test.sv @@
module json_syntax_validator_test;

    localparam int DEPTH = jsv_pkg::DEF_MAX_DEPTH;
    localparam int ITEM_COUNT = 650;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;   // hold this byte back until every verdict is in
    } t_doc_byte;

    typedef struct {
        logic ok;
        logic deep;
    } t_verdict;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // [7:0] data_byte
    logic       i_s_tlast;   // last_byte
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // [0] valid_res, [1] too_deep, [7:2] zero

    json_syntax_validator #(
        .MAX_DEPTH(DEPTH)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tlast (i_s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    t_doc_byte  byte_q[$];
    t_verdict   verdict_q[$];
    logic [7:0] doc_buf[$];
    t_doc_byte  next_byte;
    t_verdict   want;
    bit         byte_taken;
    int         bytes_sent;
    int         errors;
    int         cycles;

    // Parser state of the predictor.
    jsv_pkg::t_mode pmode;
    bit             kinds[DEPTH];   // 1 = object, 0 = array
    int unsigned    level;
    bit             key_str;
    int unsigned    hex_left;
    bit             over;

    function automatic bit is_space(logic [7:0] c);
        return c == jsv_pkg::CH_SPACE || (c >= jsv_pkg::CH_TAB && c <= jsv_pkg::CH_CR);
    endfunction

    function void clear_parser();
        pmode = jsv_pkg::M_VALUE;
        level = 0;
        key_str = 0;
        hex_left = 0;
        over = 0;
    endfunction

    function void value_closed();
        pmode = (level == 0) ? jsv_pkg::M_AFTER_TOP : jsv_pkg::M_AFTER_ELEM;
    endfunction

    function void open_level(bit obj);
        if (level >= DEPTH) begin
            over = 1;
            pmode = jsv_pkg::M_FAIL;
        end else begin
            kinds[level] = obj;
            level++;
            pmode = obj ? jsv_pkg::M_OPEN_OBJ : jsv_pkg::M_OPEN_ARR;
        end
    endfunction

    function void close_level();
        if (level == 0) begin
            pmode = jsv_pkg::M_FAIL;
        end else begin
            level--;
            value_closed();
        end
    endfunction

    function void begin_value(logic [7:0] c);
        if (c == jsv_pkg::CH_QUOTE) begin
            key_str = 0;
            pmode = jsv_pkg::M_STRING;
        end else if (c == jsv_pkg::CH_LBRACE) begin
            open_level(1);
        end else if (c == jsv_pkg::CH_LBRACK) begin
            open_level(0);
        end else if (c == jsv_pkg::CH_COMMA || c == jsv_pkg::CH_RBRACE ||
                     c == jsv_pkg::CH_RBRACK) begin
            pmode = jsv_pkg::M_FAIL;
        end else begin
            pmode = jsv_pkg::M_SCALAR;
        end
    endfunction

    // Returns 1 when a delimiter ends a scalar and must be parsed again.
    function bit parse_byte(logic [7:0] c);
        bit top;
        case (pmode)
            jsv_pkg::M_VALUE: begin
                if (!is_space(c)) begin_value(c);
            end
            jsv_pkg::M_OPEN_ARR: begin
                if (!is_space(c)) begin
                    if (c == jsv_pkg::CH_RBRACK) close_level();
                    else begin_value(c);
                end
            end
            jsv_pkg::M_OPEN_OBJ, jsv_pkg::M_KEY: begin
                if (!is_space(c)) begin
                    if (c == jsv_pkg::CH_RBRACE && pmode == jsv_pkg::M_OPEN_OBJ) begin
                        close_level();
                    end else if (c == jsv_pkg::CH_QUOTE) begin
                        key_str = 1;
                        pmode = jsv_pkg::M_STRING;
                    end else begin
                        pmode = jsv_pkg::M_FAIL;
                    end
                end
            end
            jsv_pkg::M_STRING: begin
                if (c == jsv_pkg::CH_QUOTE) begin
                    if (key_str) begin
                        key_str = 0;
                        pmode = jsv_pkg::M_COLON;
                    end else begin
                        value_closed();
                    end
                end else if (c == jsv_pkg::CH_BSLASH) begin
                    pmode = jsv_pkg::M_ESCAPE;
                end
            end
            jsv_pkg::M_ESCAPE: begin
                if (c == jsv_pkg::CH_LOW_U) begin
                    hex_left = 3;
                    pmode = jsv_pkg::M_HEX;
                end else begin
                    pmode = jsv_pkg::M_STRING;
                end
            end
            jsv_pkg::M_HEX: begin
                if (hex_left == 0) pmode = jsv_pkg::M_STRING;
                else hex_left--;
            end
            jsv_pkg::M_COLON: begin
                if (!is_space(c)) begin
                    pmode = (c == jsv_pkg::CH_COLON) ? jsv_pkg::M_VALUE : jsv_pkg::M_FAIL;
                end
            end
            jsv_pkg::M_SCALAR: begin
                if (is_space(c)) begin
                    value_closed();
                end else if (c == jsv_pkg::CH_COMMA || c == jsv_pkg::CH_RBRACE ||
                             c == jsv_pkg::CH_RBRACK) begin
                    value_closed();
                    return 1;
                end
            end
            jsv_pkg::M_AFTER_ELEM: begin
                if (!is_space(c)) begin
                    if (level == 0 || level > DEPTH) begin
                        pmode = jsv_pkg::M_FAIL;
                    end else begin
                        top = kinds[level - 1];
                        if (c == jsv_pkg::CH_COMMA) begin
                            pmode = top ? jsv_pkg::M_KEY : jsv_pkg::M_VALUE;
                        end else if ((c == jsv_pkg::CH_RBRACE && top) ||
                                     (c == jsv_pkg::CH_RBRACK && !top)) begin
                            close_level();
                        end else begin
                            pmode = jsv_pkg::M_FAIL;
                        end
                    end
                end
            end
            jsv_pkg::M_AFTER_TOP: begin
                if (!is_space(c)) pmode = jsv_pkg::M_FAIL;
            end
            default: pmode = jsv_pkg::M_FAIL;
        endcase
        return 0;
    endfunction

    function void predict_byte(logic [7:0] c, logic last);
        t_verdict v;
        if (parse_byte(c)) void'(parse_byte(c));
        if (last) begin
            v.ok = (pmode == jsv_pkg::M_AFTER_TOP ||
                    (pmode == jsv_pkg::M_SCALAR && level == 0)) && !over;
            v.deep = over;
            verdict_q.insert(verdict_q.size(), v);
            clear_parser();
        end
    endfunction

    // Document generation into doc_buf.

    function automatic void add_byte(logic [7:0] c);
        doc_buf.insert(doc_buf.size(), c);
    endfunction

    function automatic void push_ws();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0) begin
            c = 8'($urandom_range(9, 14));
            add_byte(c == 8'd14 ? jsv_pkg::CH_SPACE : c);
        end
    endfunction

    function automatic logic [7:0] scalar_char(bit first);
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (is_space(c) || c == jsv_pkg::CH_COMMA || c == jsv_pkg::CH_RBRACE ||
                   c == jsv_pkg::CH_RBRACK ||
                   (first && (c == jsv_pkg::CH_QUOTE || c == jsv_pkg::CH_LBRACE ||
                              c == jsv_pkg::CH_LBRACK)));
        return c;
    endfunction

    function automatic logic [7:0] struct_char();
        logic [7:0] picks[9];
        picks = '{jsv_pkg::CH_LBRACE, jsv_pkg::CH_LBRACK, jsv_pkg::CH_RBRACE,
                  jsv_pkg::CH_RBRACK, jsv_pkg::CH_COMMA, jsv_pkg::CH_COLON,
                  jsv_pkg::CH_QUOTE, jsv_pkg::CH_BSLASH, 8'h00};
        picks[8] = 8'($urandom_range(0, 255));
        return picks[$urandom_range(0, 8)];
    endfunction

    function automatic void gen_string();
        int n;
        logic [7:0] c;
        add_byte(jsv_pkg::CH_QUOTE);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                add_byte(jsv_pkg::CH_BSLASH);
                if ($urandom_range(0, 1) == 0) begin
                    add_byte(jsv_pkg::CH_LOW_U);
                    for (int k = 0; k < 4; k++) add_byte(8'($urandom_range(0, 255)));
                end else begin
                    add_byte(8'($urandom_range(0, 255)));
                end
            end else begin
                do c = 8'($urandom_range(0, 255));
                while (c == jsv_pkg::CH_QUOTE || c == jsv_pkg::CH_BSLASH);
                add_byte(c);
            end
        end
        add_byte(jsv_pkg::CH_QUOTE);
    endfunction

    function automatic void gen_value(int depth);
        int kind;
        int n;
        kind = (depth >= 4) ? $urandom_range(0, 1) : $urandom_range(0, 3);
        case (kind)
            0: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) add_byte(scalar_char(i == 0));
            end
            1: gen_string();
            2: begin
                add_byte(jsv_pkg::CH_LBRACK);
                push_ws();
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) add_byte(jsv_pkg::CH_COMMA);
                    push_ws();
                    gen_value(depth + 1);
                    push_ws();
                end
                if (n > 0 && $urandom_range(0, 19) == 0) add_byte(jsv_pkg::CH_COMMA);
                add_byte(jsv_pkg::CH_RBRACK);
            end
            default: begin
                add_byte(jsv_pkg::CH_LBRACE);
                push_ws();
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) add_byte(jsv_pkg::CH_COMMA);
                    push_ws();
                    gen_string();
                    push_ws();
                    add_byte(jsv_pkg::CH_COLON);
                    push_ws();
                    gen_value(depth + 1);
                    push_ws();
                end
                if (n > 0 && $urandom_range(0, 19) == 0) add_byte(jsv_pkg::CH_COMMA);
                add_byte(jsv_pkg::CH_RBRACE);
            end
        endcase
    endfunction

    // Nesting of n levels, mostly arrays, with a scalar in the middle. Past the
    // limit the document stops after the scalar, since the rest is ignored.
    function automatic void gen_nest(int n, bit closed);
        bit obj[128];
        doc_buf.delete();
        for (int i = 0; i < n; i++) begin
            obj[i] = ($urandom_range(0, 4) == 0);
            if (obj[i]) begin
                add_byte(jsv_pkg::CH_LBRACE);
                add_byte(jsv_pkg::CH_QUOTE);
                add_byte(8'h6B);
                add_byte(jsv_pkg::CH_QUOTE);
                add_byte(jsv_pkg::CH_COLON);
            end else begin
                add_byte(jsv_pkg::CH_LBRACK);
            end
        end
        add_byte(8'h30);
        if (closed) begin
            for (int i = n - 1; i >= 0; i--) begin
                add_byte(obj[i] ? jsv_pkg::CH_RBRACE : jsv_pkg::CH_RBRACK);
            end
        end
    endfunction

    function automatic void mutate_doc();
        int pos;
        pos = $urandom_range(0, doc_buf.size() - 1);
        case ($urandom_range(0, 2))
            0: if (doc_buf.size() > 1) doc_buf.delete(pos);
            1: doc_buf[pos] = struct_char();
            default: doc_buf.insert(pos, struct_char());
        endcase
    endfunction

    function automatic void queue_doc(bit drain);
        t_doc_byte b;
        for (int i = 0; i < doc_buf.size(); i++) begin
            b.data = doc_buf[i];
            b.last = (i == doc_buf.size() - 1);
            b.drain = drain && (i == 0);
            byte_q.insert(byte_q.size(), b);
        end
    endfunction

    function automatic void queue_text(string s);
        doc_buf.delete();
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
        queue_doc(0);
    endfunction

    function automatic bit steady();
        return bytes_sent >= 300 && bytes_sent < 500;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender side: a byte stays on the bus until its transfer.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || byte_taken)) begin
            if (byte_q.size() != 0 && !(byte_q[0].drain && verdict_q.size() != 0) &&
                (steady() || $urandom_range(0, 99) >= 29)) begin
                next_byte = byte_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata <= next_byte.data;
                i_s_tlast <= next_byte.last;
                bytes_sent++;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        i_m_tready <= steady() || ($urandom_range(0, 99) >= 29);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL json_syntax_validator");
            $finish;
        end else if (i_rst_n) begin
            byte_taken <= i_s_tvalid && o_s_tready;
            if (o_m_tvalid && i_m_tready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: verdict %b with none expected", $time, o_m_tdata);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_m_tdata[0] !== want.ok) begin
                        $display("%0t: valid_res expected %b actual %b",
                                 $time, want.ok, o_m_tdata[0]);
                        errors++;
                    end
                    if (o_m_tdata[1] !== want.deep) begin
                        $display("%0t: too_deep expected %b actual %b",
                                 $time, want.deep, o_m_tdata[1]);
                        errors++;
                    end
                    if (o_m_tdata[7:2] !== 6'd0) begin
                        $display("%0t: padding expected 0 actual %b", $time, o_m_tdata[7:2]);
                        errors++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) predict_byte(i_s_tdata, i_s_tlast);
        end else begin
            byte_taken <= 1'b0;
        end
    end

    initial begin
        int docs;
        int r;
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = 8'h00;
        i_s_tlast = 0;
        i_m_tready = 0;
        byte_taken = 0;
        bytes_sent = 0;
        errors = 0;
        cycles = 0;
        clear_parser();

        // Short documents: top-level scalar ended by the end, byte extremes,
        // trailing comma, an object holding an empty array, escapes, unterminated
        // string, open container, garbage after the top value and an unquoted key.
        queue_text("7");
        doc_buf = '{8'h00};
        queue_doc(0);
        doc_buf = '{8'hFF};
        queue_doc(0);
        queue_text("[1,]");
        queue_text("{\"a\":[]}");
        queue_text("\"\\u00e9\\n\"");
        queue_text("\"ab");
        queue_text("[1");
        queue_text("1 2");
        queue_text("{1:2}");

        docs = 0;
        while (byte_q.size() < ITEM_COUNT) begin
            if (docs == 2 || docs == 6 || docs == 10) begin
                // Exactly at the depth limit, and one and two levels past it.
                gen_nest(DEPTH + (docs - 2) / 4, docs == 2);
                queue_doc(0);
            end
            r = $urandom_range(0, 99);
            doc_buf.delete();
            if (r < 15) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 1) == 0) add_byte(struct_char());
                    else add_byte(8'($urandom_range(0, 255)));
                end
            end else begin
                push_ws();
                gen_value(0);
                push_ws();
                if (r < 35) mutate_doc();
            end
            queue_doc(docs == 0 || $urandom_range(0, 19) == 0);
            docs++;
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS json_syntax_validator");
        end else begin
            $display("FAIL json_syntax_validator");
        end
        $finish;
    end
endmodule
